[hdl/bont_pkg.sv]
// Package: sizes, codes and helpers shared by the binary OR net train-step block.
`default_nettype none
package bont_pkg;

  localparam int Neurons  = 64;
  localparam int Layers   = 3;
  localparam int Depth    = Layers * Neurons;
  localparam int Iw       = $clog2(Neurons);
  localparam int Cw       = $clog2(Neurons + 1);
  localparam int Aw       = $clog2(Depth);
  // |delta| is at most Neurons**3 after the last layer
  localparam int Dw       = 3 * $clog2(Neurons) + 2;

  localparam logic [63:0] LaneMask =
    (Neurons >= 64) ? {64{1'b1}} : ((64'd1 << Neurons) - 64'd1);

  typedef enum logic [1:0] {
    FuncInfer = 2'd0,
    FuncTrain = 2'd1,
    FuncWrite = 2'd2,
    FuncNone  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StIdle,
    StFwd,
    StBwd
  } state_e;

  typedef logic signed [Dw-1:0] delta_t;

  localparam logic [1:0] LastLayer = 2'(Layers - 1);

  function automatic logic [Aw-1:0] row_addr(logic [1:0] layer, logic [Iw-1:0] row);
    return Aw'(layer) * Aw'(Neurons) + Aw'(row);
  endfunction

endpackage
`default_nettype wire

[hdl/bont_if.sv]
// Interfaces: request and response channels of the binary OR net block.
`default_nettype none
interface bont_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] in_bits;
  logic [63:0] target_bits;
  logic [1:0]  layer_sel;
  logic [5:0]  row_sel;
  logic [63:0] row_word;

  modport source (output valid, func, in_bits, target_bits, layer_sel, row_sel, row_word,
                  input ready);
  modport sink   (input valid, func, in_bits, target_bits, layer_sel, row_sel, row_word,
                  output ready);
endinterface

interface bont_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bits;
  logic [63:0] goal_bits;

  modport source (output valid, out_bits, goal_bits, input ready);
  modport sink   (input valid, out_bits, goal_bits, output ready);
endinterface
`default_nettype wire

[hdl/bont_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module bont_ram #(
  parameter int Width = 64,
  parameter int Depth = 192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[hdl/binary_or_net_train_step_top.sv]
// Top level: three-layer binary OR net with integer error-driven training.
//
// Channels: req_i (sink) carries one beat per operation: infer, train step or
// weight row write. rsp_o (source) returns exactly one beat per request with
// out_bits (final-layer activation before any update) and goal_bits.
// Weight rows live in one RAM of 3*Neurons rows; one row is read per cycle
// through its single read port, and that port sets the pace.
// A row write or unused code returns its beat in the next cycle.
// Infer walks 3 layers of Neurons rows, each as row reads, a last row drain
// and a layer close, before its response. Train adds a backward pass over the
// same rows, reading and rewriting each. One request is in flight at a time;
// req_i.ready is high only when the sequencer is idle and the result register
// is free or being drained in that cycle.
// Reset: all weight rows read as zero (per-row valid bits are cleared), both
// bias words clear, no response pending.
// Stall: a held response stays in its register; the next request is taken only
// once that beat leaves.
`default_nettype none
module binary_or_net_train_step_top
  import bont_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bont_req_if.sink  req_i,
  bont_rsp_if.source rsp_o
);

  state_e state_q, state_d;

  logic [1:0]    layer_q, layer_d;
  logic [Cw-1:0] cnt_q, cnt_d;
  logic          rd_vld_q, rd_vld_d;
  logic [Iw-1:0] rd_idx_q, rd_idx_d;
  logic          rv_q, rv_d;       // row read is a written row
  logic          train_q, train_d;
  logic [Depth-1:0] wv_q, wv_d;    // per-row valid bits
  logic [63:0]   bias_q [2];
  logic [63:0]   bias_d [2];

  logic [63:0]   act_q [4];
  logic [63:0]   act_d [4];
  logic [63:0]   zv_q [3];
  logic [63:0]   zv_d [3];
  logic [63:0]   zacc_q, zacc_d;
  logic [63:0]   nb_q, nb_d;
  logic [63:0]   tgt_q, tgt_d;
  delta_t        dl_q [Neurons];
  delta_t        dl_d [Neurons];
  delta_t        nd_q [Neurons];
  delta_t        nd_d [Neurons];

  logic          out_vld_q, out_vld_d;
  logic [63:0]   out_bits_q, out_bits_d;
  logic [63:0]   goal_q, goal_d;

  logic          ram_we, ram_re;
  logic [Aw-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  logic          req_fire;
  logic          layer_done;
  logic [63:0]   row, cur_a, b_cur, zsel;
  delta_t        dhead, term;

  assign req_i.ready = (state_q == StIdle) && (!out_vld_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;
  assign layer_done  = (cnt_q == Cw'(Neurons)) && !rd_vld_q;

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.out_bits  = out_bits_q;
  assign rsp_o.goal_bits = goal_q;

  bont_ram #(.Width(64), .Depth(Depth)) u_wram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Operands of the row now leaving the RAM
  assign row   = rv_q ? ram_rdata : 64'd0;
  assign cur_a = act_q[layer_q];
  assign b_cur = (layer_q == LastLayer) ? 64'd0 : bias_q[layer_q[0]];
  assign zsel  = zv_q[layer_q];
  assign dhead = dl_q[0];

  // term = delta * (z - b), z and b single bits
  always_comb begin
    term = '0;
    if (zsel[rd_idx_q] && !b_cur[rd_idx_q]) begin
      term = dhead;
    end else if (!zsel[rd_idx_q] && b_cur[rd_idx_q]) begin
      term = -dhead;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (req_fire && (req_i.func == FuncInfer || req_i.func == FuncTrain)) begin
          state_d = StFwd;
        end
      end
      StFwd: begin
        if (layer_done && layer_q == LastLayer) begin
          state_d = train_q ? StBwd : StIdle;
        end
      end
      StBwd: begin
        if (layer_done && layer_q == 2'd0) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    layer_d    = layer_q;
    cnt_d      = cnt_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    rv_d       = rv_q;
    train_d    = train_q;
    wv_d       = wv_q;
    bias_d     = bias_q;
    act_d      = act_q;
    zv_d       = zv_q;
    zacc_d     = zacc_q;
    nb_d       = nb_q;
    tgt_d      = tgt_q;
    dl_d       = dl_q;
    nd_d       = nd_q;
    out_vld_d  = out_vld_q && !rsp_o.ready;
    out_bits_d = out_bits_q;
    goal_d     = goal_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = row_addr(layer_q, rd_idx_q);
    ram_wdata  = 64'd0;
    ram_raddr  = row_addr(layer_q, cnt_q[Iw-1:0]);

    case (state_q)
      StIdle: begin
        if (req_fire) begin
          case (req_i.func)
            FuncInfer, FuncTrain: begin
              act_d[0] = req_i.in_bits & LaneMask;
              tgt_d    = req_i.target_bits & LaneMask;
              train_d  = (req_i.func == FuncTrain);
              layer_d  = 2'd0;
              cnt_d    = '0;
              zacc_d   = 64'd0;
            end
            FuncWrite: begin
              if (req_i.layer_sel != 2'd3 && {1'b0, req_i.row_sel} < 7'(Neurons)) begin
                ram_we    = 1'b1;
                ram_waddr = row_addr(req_i.layer_sel, req_i.row_sel[Iw-1:0]);
                ram_wdata = req_i.row_word & LaneMask;
                wv_d[ram_waddr] = 1'b1;
              end
              out_vld_d  = 1'b1;
              out_bits_d = 64'd0;
              goal_d     = 64'd0;
            end
            default: begin
              out_vld_d  = 1'b1;
              out_bits_d = 64'd0;
              goal_d     = 64'd0;
            end
          endcase
        end
      end

      StFwd: begin
        if (cnt_q < Cw'(Neurons)) begin
          ram_re   = 1'b1;
          rv_d     = wv_q[ram_raddr];
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_q[Iw-1:0];
          cnt_d    = cnt_q + Cw'(1);
        end
        if (rd_vld_q) begin
          zacc_d[rd_idx_q] = |(cur_a & row);
        end
        if (layer_done) begin
          zv_d[layer_q]               = zacc_q;
          act_d[2'(layer_q + 2'd1)]   = (zacc_q ^ b_cur) & LaneMask;
          zacc_d                      = 64'd0;
          cnt_d                       = '0;
          if (layer_q == LastLayer) begin
            if (train_q) begin
              nb_d = 64'd0;
              for (int i = 0; i < Neurons; i++) begin
                nd_d[i] = '0;
                dl_d[i] = '0;
                if (zacc_q[i] && !tgt_q[i]) dl_d[i] = delta_t'(1);
                if (!zacc_q[i] && tgt_q[i]) dl_d[i] = -delta_t'(1);
              end
            end else begin
              out_vld_d  = 1'b1;
              out_bits_d = zacc_q & LaneMask;
              goal_d     = 64'd0;
            end
          end else begin
            layer_d = 2'(layer_q + 2'd1);
          end
        end
      end

      StBwd: begin
        if (cnt_q < Cw'(Neurons)) begin
          ram_re   = 1'b1;
          rv_d     = wv_q[ram_raddr];
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_q[Iw-1:0];
          cnt_d    = cnt_q + Cw'(1);
        end
        if (rd_vld_q) begin
          // back-propagate through the old row, then rewrite it
          for (int i = 0; i < Neurons; i++) begin
            nd_d[i] = nd_q[i] + (row[i] ? term : delta_t'(0));
            if (cur_a[i]) begin
              ram_wdata[i] = row[i] ? (term <= delta_t'(0)) : (term <= -delta_t'(1));
            end else begin
              ram_wdata[i] = row[i];
            end
          end
          ram_we          = 1'b1;
          wv_d[ram_waddr] = 1'b1;
          nb_d[rd_idx_q]  = b_cur[rd_idx_q] ? (term >= delta_t'(0)) : (term >= delta_t'(1));
          for (int i = 0; i < Neurons - 1; i++) begin
            dl_d[i] = dl_q[i + 1];
          end
          dl_d[Neurons-1] = '0;
        end
        if (layer_done) begin
          dl_d  = nd_q;
          cnt_d = '0;
          nb_d  = 64'd0;
          for (int i = 0; i < Neurons; i++) begin
            nd_d[i] = '0;
          end
          if (layer_q != LastLayer) begin
            bias_d[layer_q[0]] = nb_q & LaneMask;
          end
          if (layer_q == 2'd0) begin
            out_vld_d  = 1'b1;
            out_bits_d = act_q[3];
            goal_d     = 64'd0;
            for (int i = 0; i < Neurons; i++) begin
              goal_d[i] = act_q[0][i] ? (nd_q[i] <= delta_t'(0)) : (nd_q[i] <= -delta_t'(1));
            end
          end else begin
            layer_d = 2'(layer_q - 2'd1);
          end
        end
      end

      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      layer_q   <= 2'd0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      rv_q      <= 1'b0;
      train_q   <= 1'b0;
      wv_q      <= '0;
      bias_q[0] <= 64'd0;
      bias_q[1] <= 64'd0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      layer_q   <= layer_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      rv_q      <= rv_d;
      train_q   <= train_d;
      wv_q      <= wv_d;
      bias_q    <= bias_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    act_q      <= act_d;
    zv_q       <= zv_d;
    zacc_q     <= zacc_d;
    nb_q       <= nb_d;
    tgt_q      <= tgt_d;
    dl_q       <= dl_d;
    nd_q       <= nd_d;
    out_bits_q <= out_bits_d;
    goal_q     <= goal_d;
  end

  // Checks
  a_layer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    layer_q != 2'd3)
    else $error("layer index out of range");

  a_rd_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == StFwd || state_q == StBwd))
    else $error("row read outstanding outside a pass");

  a_we_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == StIdle || state_q == StBwd))
    else $error("weight write during forward pass");

  a_infer_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.func == FuncInfer) |=> (state_q == StFwd && layer_q == 2'd0))
    else $error("infer did not start forward pass");

endmodule
`default_nettype wire
